[design/sine_oscillator_mix_decay_macros.svh]
// Assertion shorthands shared by the oscillator modules.
`ifndef SINE_OSCILLATOR_MIX_DECAY_MACROS_SVH
`define SINE_OSCILLATOR_MIX_DECAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/smd_pkg.sv]
`default_nettype none

package smd_pkg;

    // Default sizes of the sample path and the phase accumulator.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int PHASE_BITS_DEF  = 32;

    // Fixed field widths.
    localparam int FUNC_W      = 2;
    localparam int PHASE_OUT_W = 32;
    localparam int STEP_W      = 32;
    localparam int GAIN_W      = 24;
    localparam int DECAY_W     = 25;
    localparam int FOLD_W      = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Function codes of an input transaction.
    localparam logic [FUNC_W-1:0] FN_GEN     = 2'd0;
    localparam logic [FUNC_W-1:0] FN_MIX     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_GAIN  = 2'd1;

    // Reset values.
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd4194304;
    localparam logic [DECAY_W-1:0] DECAY_ONE  = 25'd16777216;

    // Arithmetic constants: pi/2 and the polynomial in Q2.30, 0.9999 in Q1.24.
    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [31:0] COEF9       = 32'sd2959;
    localparam logic signed [31:0] COEF7       = -32'sd213042;
    localparam logic signed [31:0] COEF5       = 32'sd8947849;
    localparam logic signed [31:0] COEF3       = -32'sd178956971;
    localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
    localparam logic signed [31:0] DECAY_MUL   = 32'sd16775538;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_WAIT
    } t_state;

    // Operations of the shared multiplier, in the order they run.
    typedef enum logic [3:0] {
        OP_X,
        OP_X2,
        OP_H7,
        OP_H5,
        OP_H3,
        OP_H1,
        OP_SIN,
        OP_SCL,
        OP_TONE,
        OP_DECAY,
        OP_MIX
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_en;
        logic rnd_en;
        logic commit;
        t_op  op;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mix;
    } t_status;

endpackage

`default_nettype wire

[design/smd_if.sv]
`default_nettype none

// Input sample channel.
interface smd_in_if #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [smd_pkg::FUNC_W-1:0]       func;
    logic signed [SAMPLE_BITS-1:0]    in_sample;
    logic                             in_last;

    modport source (output valid, func, in_sample, in_last, input ready);
    modport sink   (input valid, func, in_sample, in_last, output ready);
endinterface

// Result sample channel.
interface smd_out_if #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       out_sample;
    logic [smd_pkg::PHASE_OUT_W-1:0]     phase_now;
    logic                                out_last;

    modport source (output valid, out_sample, phase_now, out_last, input ready);
    modport sink   (input valid, out_sample, phase_now, out_last, output ready);
endinterface

// Configuration write channel.
interface smd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [smd_pkg::CFG_IDX_W-1:0]      index;
    logic [smd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/smd_ctrl.sv]
`default_nettype none
`include "sine_oscillator_mix_decay_macros.svh"

module smd_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [smd_pkg::FUNC_W-1:0] i_in_func,
    output logic                       o_in_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    input  smd_pkg::t_status           i_status,
    output smd_pkg::t_cmd              o_cmd
);

    smd_pkg::t_state r_state, n_state;
    smd_pkg::t_op    r_op, n_op;
    logic            r_out_valid, n_out_valid;

    // State, operation and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smd_pkg::ST_IDLE;
            r_op        <= smd_pkg::OP_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and next operation.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            smd_pkg::ST_IDLE: begin
                n_op = smd_pkg::OP_X;
                if (i_in_valid) begin
                    if (i_in_func inside {smd_pkg::FN_GEN, smd_pkg::FN_MIX}) begin
                        n_state = smd_pkg::ST_MUL;
                    end else begin
                        n_state = smd_pkg::ST_WAIT;
                    end
                end
            end
            smd_pkg::ST_MUL: begin
                n_state = smd_pkg::ST_RND;
            end
            smd_pkg::ST_RND: begin
                if (r_op == smd_pkg::OP_MIX ||
                    (r_op == smd_pkg::OP_TONE && !i_status.mix)) begin
                    n_state = smd_pkg::ST_WAIT;
                end else begin
                    n_state = smd_pkg::ST_MUL;
                end
                case (r_op)
                    smd_pkg::OP_X:     n_op = smd_pkg::OP_X2;
                    smd_pkg::OP_X2:    n_op = smd_pkg::OP_H7;
                    smd_pkg::OP_H7:    n_op = smd_pkg::OP_H5;
                    smd_pkg::OP_H5:    n_op = smd_pkg::OP_H3;
                    smd_pkg::OP_H3:    n_op = smd_pkg::OP_H1;
                    smd_pkg::OP_H1:    n_op = smd_pkg::OP_SIN;
                    smd_pkg::OP_SIN:   n_op = smd_pkg::OP_SCL;
                    smd_pkg::OP_SCL:   n_op = smd_pkg::OP_TONE;
                    smd_pkg::OP_TONE:  n_op = smd_pkg::OP_DECAY;
                    smd_pkg::OP_DECAY: n_op = smd_pkg::OP_MIX;
                    default:           n_op = smd_pkg::OP_X;
                endcase
            end
            smd_pkg::ST_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = smd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smd_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_in_ready    = (r_state == smd_pkg::ST_IDLE);
        o_cmd.load    = o_in_ready && i_in_valid;
        o_cmd.mul_en  = (r_state == smd_pkg::ST_MUL);
        o_cmd.rnd_en  = (r_state == smd_pkg::ST_RND);
        o_cmd.commit  = (r_state == smd_pkg::ST_WAIT) && (!r_out_valid || i_out_ready);
        o_cmd.op      = r_op;
        o_out_valid   = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // A newly loaded transaction must take the controller out of idle.
    `SMD_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, o_cmd.load, r_state != smd_pkg::ST_IDLE, "load did not leave idle")
    // Every multiply is followed by its rounding cycle.
    `SMD_ASSERT_NEXT(a_mul_then_rnd, i_clk, i_rst_n, r_state == smd_pkg::ST_MUL, r_state == smd_pkg::ST_RND, "multiply not followed by rounding")
    // Decay and mix steps only run for a mix transaction.
    `SMD_ASSERT_SAME(a_decay_only_mix, i_clk, i_rst_n, (r_state == smd_pkg::ST_MUL || r_state == smd_pkg::ST_RND) && (r_op == smd_pkg::OP_DECAY || r_op == smd_pkg::OP_MIX), i_status.mix, "decay step outside mix mode")
    // A committed result is presented on the next cycle.
    `SMD_ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, o_cmd.commit, r_out_valid, "committed result not presented")

endmodule

`default_nettype wire

[design/smd_dp.sv]
`default_nettype none
`include "sine_oscillator_mix_decay_macros.svh"

module smd_dp #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = smd_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smd_pkg::t_cmd                     i_cmd,
    output smd_pkg::t_status                  o_status,
    input  logic [smd_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [SAMPLE_BITS-1:0]     i_in_sample,
    input  logic                              i_in_last,
    input  logic                              i_cfg_we,
    input  logic [smd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [smd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic signed [SAMPLE_BITS-1:0]     o_out_sample,
    output logic [smd_pkg::PHASE_OUT_W-1:0]   o_phase_now,
    output logic                              o_out_last
);

    // Operand width covers the Q2.30 values and the widest mix sum.
    localparam int MW      = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;
    localparam int PW      = 2 * MW;
    localparam int SCL_SH  = (SAMPLE_BITS < 31) ? 31 - SAMPLE_BITS : 0;
    localparam int SCL_HSH = (SCL_SH > 0) ? SCL_SH - 1 : 0;
    localparam int SCL_UP  = (SAMPLE_BITS > 31) ? SAMPLE_BITS - 31 : 0;
    localparam logic signed [PW-1:0] ONE_P   = PW'(1);
    localparam logic signed [MW-1:0] SCL_MUL = MW'(1) <<< SCL_UP;
    localparam logic signed [MW-1:0] SAT_HI  = (MW'(1) <<< (SAMPLE_BITS - 1)) - MW'(1);
    localparam logic signed [MW-1:0] SAT_LO  = -SAT_HI - MW'(1);

    // Configuration and oscillator state.
    logic [smd_pkg::STEP_W-1:0]   r_phase_step;
    logic [smd_pkg::GAIN_W-1:0]   r_tone_gain;
    logic [PHASE_BITS-1:0]        r_phase;
    logic [smd_pkg::DECAY_W-1:0]  r_decay;

    // Captured transaction.
    logic [smd_pkg::FUNC_W-1:0]   r_func;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                         r_last;
    logic                         r_neg;

    // Working registers of the polynomial datapath.
    logic signed [MW-1:0]         r_x;
    logic signed [MW-1:0]         r_x2;
    logic signed [MW-1:0]         r_acc;
    logic signed [PW-1:0]         r_prod;

    // Result register.
    logic signed [SAMPLE_BITS-1:0]   r_out_sample;
    logic [smd_pkg::PHASE_OUT_W-1:0] r_out_phase;
    logic                            r_out_last;

    logic [smd_pkg::PHASE_OUT_W-1:0] fold_p;
    logic [smd_pkg::FOLD_W-1:0]      fold_f;
    logic signed [MW-1:0]            mul_a;
    logic signed [MW-1:0]            mul_b;
    logic signed [PW-1:0]            prod;
    logic signed [PW-1:0]            neg_p;
    logic signed [PW-1:0]            half30;
    logic signed [PW-1:0]            mix_term;
    logic signed [PW-1:0]            bias;
    logic signed [PW-1:0]            rnd_sum;
    logic signed [MW-1:0]            rnd_val;
    logic [PHASE_BITS-1:0]           n_phase;
    logic signed [SAMPLE_BITS-1:0]   n_sat;

    // Quadrant fold: left-align the phase, mirror the odd quadrants.
    assign fold_p = smd_pkg::PHASE_OUT_W'(r_phase) << (smd_pkg::PHASE_OUT_W - PHASE_BITS);
    assign fold_f = fold_p[29:7] ^ {smd_pkg::FOLD_W{fold_p[30]}};

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = r_acc;
        mul_b = r_x2;
        case (i_cmd.op)
            smd_pkg::OP_X: begin
                mul_a = r_x;
                mul_b = MW'(smd_pkg::HALF_PI_Q30);
            end
            smd_pkg::OP_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            smd_pkg::OP_SIN: begin
                // Negating x gives the lower half of the turn; rounding is symmetric.
                mul_b = r_neg ? -r_x : r_x;
            end
            smd_pkg::OP_SCL: begin
                mul_b = SCL_MUL;
            end
            smd_pkg::OP_TONE: begin
                mul_b = MW'($signed({1'b0, r_tone_gain}));
            end
            smd_pkg::OP_DECAY: begin
                mul_a = MW'($signed({1'b0, r_decay}));
                mul_b = MW'(smd_pkg::DECAY_MUL);
            end
            smd_pkg::OP_MIX: begin
                mul_b = MW'($signed({1'b0, r_decay}));
            end
            default: begin
                mul_a = r_acc;
                mul_b = r_x2;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // Rounding: half minus one for negative products gives ties away from zero.
    // Horner coefficients and the mixed-in sample ride in the same addition.
    assign neg_p    = $signed({{(PW-1){1'b0}}, r_prod[PW-1]});
    assign half30   = (ONE_P <<< 29) - neg_p;
    assign mix_term = (r_func == smd_pkg::FN_MIX) ? (PW'(r_sample) <<< 22) : ONE_P - ONE_P;

    always_comb begin
        case (i_cmd.op)
            smd_pkg::OP_X:     bias = (ONE_P <<< 22) - neg_p;
            smd_pkg::OP_X2:    bias = half30;
            smd_pkg::OP_H7:    bias = half30 + (PW'(smd_pkg::COEF7) <<< 30);
            smd_pkg::OP_H5:    bias = half30 + (PW'(smd_pkg::COEF5) <<< 30);
            smd_pkg::OP_H3:    bias = half30 + (PW'(smd_pkg::COEF3) <<< 30);
            smd_pkg::OP_H1:    bias = half30 + (PW'(smd_pkg::Q30_ONE) <<< 30);
            smd_pkg::OP_SIN:   bias = half30;
            smd_pkg::OP_SCL:   bias = (SCL_SH > 0) ? (ONE_P <<< SCL_HSH) - neg_p : ONE_P - ONE_P;
            smd_pkg::OP_TONE:  bias = (ONE_P <<< 21) - neg_p + mix_term;
            smd_pkg::OP_DECAY: bias = (ONE_P <<< 23) - neg_p;
            smd_pkg::OP_MIX:   bias = (ONE_P <<< 23) - neg_p;
            default:           bias = half30;
        endcase
        rnd_sum = r_prod + bias;
        case (i_cmd.op)
            smd_pkg::OP_X:     rnd_val = MW'(rnd_sum >>> 23);
            smd_pkg::OP_SCL:   rnd_val = MW'(rnd_sum >>> SCL_SH);
            smd_pkg::OP_TONE:  rnd_val = MW'(rnd_sum >>> 22);
            smd_pkg::OP_DECAY: rnd_val = MW'(rnd_sum >>> 24);
            smd_pkg::OP_MIX:   rnd_val = MW'(rnd_sum >>> 24);
            default:           rnd_val = MW'(rnd_sum >>> 30);
        endcase
    end

    // Phase advance and output saturation.
    assign n_phase = r_phase + r_phase_step[PHASE_BITS-1:0];

    always_comb begin
        if (r_acc > SAT_HI) begin
            n_sat = SAMPLE_BITS'(SAT_HI);
        end else if (r_acc < SAT_LO) begin
            n_sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            n_sat = SAMPLE_BITS'(r_acc);
        end
    end

    // Configuration registers, phase and decay state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_tone_gain  <= smd_pkg::GAIN_RESET;
            r_phase      <= '0;
            r_decay      <= smd_pkg::DECAY_ONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smd_pkg::REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    smd_pkg::REG_TONE_GAIN:  r_tone_gain  <= i_cfg_data[smd_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.rnd_en && i_cmd.op == smd_pkg::OP_DECAY) begin
                r_decay <= smd_pkg::DECAY_W'(rnd_val);
            end
            if (i_cmd.commit) begin
                case (r_func)
                    smd_pkg::FN_GEN, smd_pkg::FN_MIX: begin
                        r_phase <= n_phase;
                    end
                    smd_pkg::FN_RESTART: begin
                        r_phase <= '0;
                        r_decay <= smd_pkg::DECAY_ONE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Transaction capture, product register and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_sample <= i_in_sample;
            r_last   <= i_in_last;
            r_x      <= MW'($signed({1'b0, fold_f}));
            r_neg    <= fold_p[31];
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        if (i_cmd.rnd_en) begin
            case (i_cmd.op)
                smd_pkg::OP_X: begin
                    r_x <= rnd_val;
                end
                smd_pkg::OP_X2: begin
                    r_x2  <= rnd_val;
                    r_acc <= MW'(smd_pkg::COEF9);
                end
                smd_pkg::OP_DECAY: ;
                default: begin
                    r_acc <= rnd_val;
                end
            endcase
        end
    end

    // Result register, written once the previous result has left.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_last <= r_last;
            case (r_func)
                smd_pkg::FN_GEN, smd_pkg::FN_MIX: begin
                    r_out_sample <= n_sat;
                    r_out_phase  <= smd_pkg::PHASE_OUT_W'(n_phase);
                end
                smd_pkg::FN_RESTART: begin
                    r_out_sample <= '0;
                    r_out_phase  <= '0;
                end
                default: begin
                    r_out_sample <= '0;
                    r_out_phase  <= smd_pkg::PHASE_OUT_W'(r_phase);
                end
            endcase
        end
    end

    assign o_status.mix = (r_func == smd_pkg::FN_MIX);
    assign o_out_sample = r_out_sample;
    assign o_phase_now  = r_out_phase;
    assign o_out_last   = r_out_last;

    // The decay factor never exceeds unity: it only shrinks, until a restart sets it back to unity.
    `SMD_ASSERT_SAME(a_decay_bound, i_clk, i_rst_n, 1'b1, r_decay <= smd_pkg::DECAY_ONE, "decay factor above unity")
    // A restart leaves both the accumulator and the reported phase at zero.
    `SMD_ASSERT_NEXT(a_restart_phase, i_clk, i_rst_n, i_cmd.commit && r_func == smd_pkg::FN_RESTART, r_out_phase == '0 && r_phase == '0, "restart did not clear the phase")

endmodule

`default_nettype wire

[design/sine_oscillator_mix_decay.sv]
// Phase-accumulator sine oscillator with an optional decaying mix. Each input transaction
// either generates one tone sample (sine of the phase times tone_gain), mixes that tone
// into in_sample and scales the sum by a decay factor that shrinks by 0.9999 per sample,
// or restarts the phase and the decay; each yields exactly one result transaction. The
// sine comes from a quadrant fold and a degree-9 odd polynomial evaluated by Horner steps
// on a single shared multiplier, and every multiply is followed by a rounding step. The
// block works on one transaction at a time: generate runs nine multiplies and mix runs
// eleven, while restart and the unused code run none; the result is registered once the
// work ends and any earlier result has been taken, and a new transaction is accepted
// while that result still waits to be taken. Writes to phase_step and tone_gain are
// always accepted and must be made while the block is idle.
`default_nettype none

module sine_oscillator_mix_decay #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = smd_pkg::PHASE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smd_in_if.sink     i_in,
    smd_out_if.source  o_out,
    smd_cfg_if.sink    i_cfg
);

    smd_pkg::t_cmd    cmd;
    smd_pkg::t_status status;
    logic             cfg_we;

    // Configuration writes complete in the cycle they are offered.
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid & i_cfg.ready;

    // Sequencer for the shared multiplier and the handshakes.
    smd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Phase, decay, polynomial arithmetic and result register.
    smd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_in.func),
        .i_in_sample  (i_in.in_sample),
        .i_in_last    (i_in.in_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_out_sample (o_out.out_sample),
        .o_phase_now  (o_out.phase_now),
        .o_out_last   (o_out.out_last)
    );

endmodule

`default_nettype wire

[dv/tb_sine_oscillator_mix_decay.sv]
module tb_sine_oscillator_mix_decay;
    import smd_pkg::*;

    localparam int SW            = SAMPLE_BITS_DEF;
    localparam int N_PHASES      = 30;
    localparam int ITEMS_PER_PH  = 55;
    localparam int HOLD_PHASE    = 3;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 5000;

    // The function code and register indexes that the block does not decode.
    localparam logic [FUNC_W-1:0]    FN_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] sample;
        logic [31:0]          phase;
        logic                 last;
    } osc_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [FUNC_W-1:0]    fn;
        logic signed [SW-1:0] smp;
        logic                 lst;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        logic                 known;
        logic signed [SW-1:0] exp_smp;
        logic [31:0]          exp_phase;
    } dir_row_t;

    logic clk;
    logic rst_n;

    smd_in_if  in_ch ();
    smd_out_if out_ch ();
    smd_cfg_if cfg_ch ();

    sine_oscillator_mix_decay dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Oscillator state and registers as the testbench believes them to be.
    logic [31:0]          osc_phase = '0;
    logic [DECAY_W-1:0]   osc_decay = DECAY_ONE;
    logic [31:0]          osc_step  = '0;
    logic [GAIN_W-1:0]    osc_gain  = GAIN_RESET;

    osc_result_t pending_results[$];
    osc_result_t front_result;
    dir_row_t    dir_rows[$];

    // Typed-in expectation that travels with the item being offered.
    logic                 row_known;
    logic signed [SW-1:0] row_exp_sample;
    logic [31:0]          row_exp_phase;

    logic hold_go;
    int   n_fail = 0;
    int   quiet_cycles = 0;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Right shift that rounds to nearest, ties away from zero.
    function automatic longint round_shift(longint v, int sh);
        longint unsigned m;
        if (sh == 0) return v;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [SW-1:0] clamp_sample(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return S_MAX;
        if (v < lo) return S_MIN;
        return v[SW-1:0];
    endfunction

    // Sine of a phase in Q1.(SW-1): quadrant fold, then the odd polynomial by Horner.
    function automatic longint sine_q(logic [31:0] p);
        longint f;
        longint x;
        longint x2;
        longint acc;
        longint s;
        f = {41'd0, p[29:7]};
        if (p[30]) f = f ^ 64'h7f_ffff;
        x   = round_shift(f * HALF_PI_Q30, 23);
        x2  = round_shift(x * x, 30);
        acc = COEF9;
        acc = round_shift(acc * x2, 30) + COEF7;
        acc = round_shift(acc * x2, 30) + COEF5;
        acc = round_shift(acc * x2, 30) + COEF3;
        acc = round_shift(acc * x2, 30) + Q30_ONE;
        s   = round_shift(acc * x, 30);
        if (p[31]) s = -s;
        return round_shift(s, 31 - SW);
    endfunction

    // Advances the oscillator by one input transaction and returns its result.
    function automatic osc_result_t predict_sample(logic [FUNC_W-1:0] fn,
                                                   logic signed [SW-1:0] smp, logic lst);
        osc_result_t r;
        longint      tone;
        longint      d;
        r.sample = '0;
        r.last   = lst;
        case (fn)
            FN_RESTART: begin
                osc_phase = '0;
                osc_decay = DECAY_ONE;
            end
            FN_GEN, FN_MIX: begin
                tone = round_shift(sine_q(osc_phase) * longint'({40'd0, osc_gain}), 22);
                osc_phase = osc_phase + osc_step;
                if (fn == FN_GEN) begin
                    r.sample = clamp_sample(tone);
                end else begin
                    d = {39'd0, osc_decay};
                    d = (d * DECAY_MUL + 64'sd8388608) >>> 24;
                    osc_decay = d[DECAY_W-1:0];
                    d = {39'd0, osc_decay};
                    r.sample = clamp_sample(round_shift((longint'(smp) + tone) * d, 24));
                end
            end
            default: begin
            end
        endcase
        r.phase = osc_phase;
        return r;
    endfunction

    task automatic note_mismatch(string field, longint want, longint got);
        n_fail++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Score outgoing results, then track register writes and accepted input transactions.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    n_fail++;
                    $error("result transaction arrived with no expectation waiting");
                end else begin
                    front_result = pending_results.pop_front();
                    if (out_ch.out_sample !== front_result.sample)
                        note_mismatch("out_sample", front_result.sample, out_ch.out_sample);
                    if (out_ch.phase_now !== front_result.phase)
                        note_mismatch("phase_now", front_result.phase, out_ch.phase_now);
                    if (out_ch.out_last !== front_result.last)
                        note_mismatch("out_last", front_result.last, out_ch.out_last);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_PHASE_STEP)
                    osc_step = cfg_ch.data;
                else if (cfg_ch.index == REG_TONE_GAIN)
                    osc_gain = cfg_ch.data[GAIN_W-1:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                front_result = predict_sample(in_ch.func, in_ch.in_sample, in_ch.in_last);
                if (row_known) begin
                    front_result.sample = row_exp_sample;
                    front_result.phase  = row_exp_phase;
                end
                pending_results.push_back(front_result);
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind moves for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** sine_oscillator_mix_decay: FAILED **");
            $finish;
        end
    end

    // Idle stretch: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Result side: random stalls, long ready runs, and one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic offer_item(input logic [FUNC_W-1:0] fn, input logic signed [SW-1:0] smp,
                              input logic lst, input int gap, input logic known,
                              input logic signed [SW-1:0] k_smp, input logic [31:0] k_phase);
        in_ch.valid     <= 1'b1;
        in_ch.func      <= fn;
        in_ch.in_sample <= smp;
        in_ch.in_last   <= lst;
        row_known       <= known;
        row_exp_sample  <= k_smp;
        row_exp_phase   <= k_phase;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic dir_row_t item_row(logic [FUNC_W-1:0] fn, logic signed [SW-1:0] smp,
                                          logic lst);
        dir_row_t row;
        row = '{ROW_ITEM, fn, smp, lst, REG_PHASE_STEP, '0, 1'b0, '0, '0};
        return row;
    endfunction

    function automatic dir_row_t known_row(logic [FUNC_W-1:0] fn, logic signed [SW-1:0] smp,
                                           logic lst, logic signed [SW-1:0] exp_smp,
                                           logic [31:0] exp_phase);
        dir_row_t row;
        row = '{ROW_ITEM, fn, smp, lst, REG_PHASE_STEP, '0, 1'b1, exp_smp, exp_phase};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        dir_row_t row;
        row = '{ROW_CFG, FN_GEN, '0, 1'b0, idx, data, 1'b0, '0, '0};
        return row;
    endfunction

    // Stimulus: reset, directed table, then randomised phases.
    initial begin
        int                   gap_pct;
        int                   restart_pct;
        int                   r;
        logic [FUNC_W-1:0]    fn;
        logic signed [SW-1:0] smp;
        logic [31:0]          step_val;
        logic [GAIN_W-1:0]    gain_val;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FN_GEN;
        in_ch.in_sample <= '0;
        in_ch.in_last   <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_PHASE_STEP;
        cfg_ch.data     <= '0;
        row_known       <= 1'b0;
        row_exp_sample  <= '0;
        row_exp_phase   <= '0;
        hold_go         <= 1'b0;

        dir_rows = '{
            // Reset state, extremes of the mixed sample, unused code and restart.
            known_row(FN_GEN, '0, 1'b0, '0, 32'h0),
            item_row(FN_MIX, S_MAX, 1'b1),
            item_row(FN_MIX, S_MIN, 1'b0),
            known_row(FN_UNUSED, {SW{1'b1}}, 1'b1, '0, 32'h0),
            known_row(FN_RESTART, 24'sh5a5a5a, 1'b0, '0, 32'h0),
            // Quarter-turn steps visit both peaks and both zero crossings.
            cfg_row(REG_PHASE_STEP, 32'h4000_0000),
            known_row(FN_GEN, '0, 1'b1, '0, 32'h4000_0000),
            item_row(FN_GEN, '0, 1'b0),
            known_row(FN_GEN, S_MAX, 1'b0, '0, 32'hc000_0000),
            item_row(FN_GEN, S_MIN, 1'b1),
            item_row(FN_GEN, '0, 1'b0),
            item_row(FN_MIX, S_MAX, 1'b0),
            item_row(FN_GEN, '0, 1'b1),
            item_row(FN_MIX, S_MIN, 1'b0),
            // Largest gain drives the tone into saturation.
            cfg_row(REG_TONE_GAIN, 32'h00ff_ffff),
            item_row(FN_GEN, '0, 1'b0),
            item_row(FN_GEN, '0, 1'b1),
            item_row(FN_GEN, '0, 1'b0),
            item_row(FN_GEN, '0, 1'b1),
            cfg_row(REG_TONE_GAIN, 32'h0),
            item_row(FN_MIX, 24'sh123456, 1'b1),
            cfg_row(REG_PHASE_STEP, 32'h8000_0000),
            item_row(FN_GEN, '0, 1'b0),
            item_row(FN_MIX, S_MIN, 1'b1),
            // Writes to undecoded indexes must leave both registers alone.
            cfg_row(REG_SPARE_A, 32'hffff_ffff),
            cfg_row(REG_SPARE_B, 32'h0000_1234),
            cfg_row(REG_PHASE_STEP, 32'h7fff_ffff),
            cfg_row(REG_TONE_GAIN, {8'hff, GAIN_RESET}),
            item_row(FN_GEN, '0, 1'b0),
            item_row(FN_UNUSED, S_MAX, 1'b0),
            known_row(FN_RESTART, S_MIN, 1'b1, '0, 32'h0),
            cfg_row(REG_PHASE_STEP, 32'hffff_ffff),
            known_row(FN_GEN, S_MAX, 1'b0, '0, 32'hffff_ffff),
            item_row(FN_GEN, '0, 1'b1),
            item_row(FN_MIX, 24'sh000001, 1'b0),
            item_row(FN_MIX, {SW{1'b1}}, 1'b1)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                offer_item(dir_rows[k].fn, dir_rows[k].smp, dir_rows[k].lst,
                           ($urandom_range(0, 2) == 0) ? idle_len() : 0,
                           dir_rows[k].known, dir_rows[k].exp_smp, dir_rows[k].exp_phase);
            end
        end

        // Random phases; each first waits for an idle block and may then write registers.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0: step_val = $urandom_range(1, 1 << 22);
                    1: step_val = -$urandom_range(1, 1 << 22);
                    2: step_val = $urandom();
                    3: begin
                        r = $urandom_range(0, 4);
                        step_val = (r == 0) ? 32'h0 : (r == 1) ? 32'h7fff_ffff :
                                   (r == 2) ? 32'h8000_0000 : (r == 3) ? 32'hffff_ffff :
                                   32'h1;
                    end
                    default: step_val = $urandom_range(0, 1 << 27);
                endcase
                write_reg(REG_PHASE_STEP, step_val);
            end
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 3))
                    0: gain_val = $urandom_range(0, (1 << GAIN_W) - 1);
                    1: begin
                        r = $urandom_range(0, 2);
                        gain_val = (r == 0) ? '0 : (r == 1) ? {GAIN_W{1'b1}} : GAIN_RESET;
                    end
                    default: gain_val = $urandom_range(1 << 20, 1 << 23);
                endcase
                write_reg(REG_TONE_GAIN, {8'($urandom()), gain_val});
            end
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());

            gap_pct     = (ph % 4 == 0) ? 0 : $urandom_range(10, 50);
            restart_pct = ($urandom_range(0, 2) == 0) ? 0 : 8;
            if (ph == HOLD_PHASE) begin
                hold_go <= 1'b1;
                gap_pct = 0;
            end

            for (int i = 0; i < ITEMS_PER_PH; i++) begin
                r = $urandom_range(0, 99);
                if (r < restart_pct)
                    fn = FN_RESTART;
                else if (r < restart_pct + 6)
                    fn = FN_UNUSED;
                else if (r < 45)
                    fn = FN_GEN;
                else
                    fn = FN_MIX;
                r = $urandom_range(0, 99);
                if (r < 3)
                    smp = S_MAX;
                else if (r < 6)
                    smp = S_MIN;
                else if (r < 8)
                    smp = '0;
                else
                    smp = SW'($urandom());
                offer_item(fn, smp, 1'($urandom()),
                           ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0,
                           1'b0, '0, '0);
            end
        end

        // Drain, then allow for a stray late result.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            n_fail++;
            $error("%0d expected results never arrived", pending_results.size());
        end
        if (n_fail == 0)
            $display("** sine_oscillator_mix_decay: PASSED **");
        else
            $display("** sine_oscillator_mix_decay: FAILED **");
        $finish;
    end

endmodule
